### design/stw_pkg.sv
// ----------------------------------------------------------------------------
// stw_pkg: shared types and constants of the strided tensor address walker
// Register indexes, mode codes, configuration and queue entry structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stw_pkg;

    localparam int DATA_BITS      = 32;
    localparam int INDEX_BITS     = 24;
    localparam int COUNT_BITS     = 25;
    localparam int CFG_BITS       = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int QUEUE_DEPTH    = 2;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE          = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_COUNT     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_OFFSET   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXTENTS       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDES       = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ELEMENT_COUNT = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_VALUE    = 3'd6;

    // walk modes; the unused code behaves as gather
    localparam logic [1:0] MODE_GATHER  = 2'd0;
    localparam logic [1:0] MODE_SCATTER = 2'd1;
    localparam logic [1:0] MODE_FILL    = 2'd2;

    typedef struct packed {
        logic [1:0]            mode;
        logic [2:0]            dim_count;
        logic [31:0]           base_offset;
        logic [COUNT_BITS-1:0] element_count;
        logic [DATA_BITS-1:0]  fill_value;
    } stw_cfg_t;

    // per-beat fields that ride the queue next to the position snapshot
    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic [DATA_BITS-1:0]  data;
        logic                  last;
    } stw_item_t;

    // dimensions in use: zero counts as one, clamp at the maximum
    function automatic logic [3:0] used_dims(logic [2:0] dim_count, int max_dims);
        logic [3:0] n;
        n = {1'b0, dim_count};
        if (n == 4'd0)
            n = 4'd1;
        if (n > 4'(max_dims))
            n = 4'(max_dims);
        return n;
    endfunction

endpackage

### design/stw_front.sv
// ----------------------------------------------------------------------------
// stw_front: odometer front end
// Accepts input beats, snapshots the position counters, picks the write data,
// flags the final element and advances the odometer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stw_front #(
    parameter int MAX_DIMS    = 4,
    parameter int EXTENT_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  stw_pkg::stw_cfg_t                         cfg,
    input  logic [stw_pkg::CFG_BITS-1:0]              extents,
    input  logic                                      in_valid,
    input  logic [stw_pkg::DATA_BITS-1:0]             data_in,
    output logic                                      in_stall,
    input  logic                                      queue_full,
    output logic                                      push,
    output logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]      push_pos,
    output stw_pkg::stw_item_t                        push_item
);

    localparam int SPAN = MAX_DIMS * EXTENT_BITS + stw_pkg::CFG_BITS;

    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] pos_reg;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] pos_next;
    logic [stw_pkg::INDEX_BITS-1:0]       index_reg;
    logic [stw_pkg::INDEX_BITS-1:0]       index_next;

    logic [SPAN-1:0]                      ext_padded;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] ext_vec;
    logic [MAX_DIMS:0]                    wrap;
    logic [MAX_DIMS:0]                    carry;
    logic [3:0]                           n_dims;
    logic                                 last;
    logic                                 accept;

    // dimensions beyond the packed word read as zero extent
    assign ext_padded = SPAN'(extents);
    assign ext_vec    = ext_padded[MAX_DIMS*EXTENT_BITS-1:0];
    assign n_dims     = stw_pkg::used_dims(cfg.dim_count, MAX_DIMS);

    assign accept   = in_valid && !queue_full;
    assign in_stall = queue_full;
    assign push     = accept;

    assign last = ((stw_pkg::COUNT_BITS'(index_reg) + stw_pkg::COUNT_BITS'(1))
                   == cfg.element_count);

    // odometer carry chain, innermost used dimension first
    always_comb
    begin
        wrap[MAX_DIMS]  = 1'b0;
        carry[MAX_DIMS] = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            wrap[d] = ((EXTENT_BITS+1)'(pos_reg[d]) + (EXTENT_BITS+1)'(1))
                      >= (EXTENT_BITS+1)'(ext_vec[d]);
        end
        for (int d = MAX_DIMS - 1; d >= 0; d--)
        begin
            carry[d] = (4'(d) == (n_dims - 4'd1)) || (carry[d+1] && wrap[d+1]);
        end
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            pos_next[d] = pos_reg[d];
            if (carry[d])
            begin
                // the outermost dimension never carries; it is not cleared at its extent and keeps counting
                if (d != 0 && wrap[d])
                    pos_next[d] = '0;
                else
                    pos_next[d] = pos_reg[d] + EXTENT_BITS'(1);
            end
        end
        index_next = index_reg + stw_pkg::INDEX_BITS'(1);
    end

    // write data select
    always_comb
    begin
        push_item.index = index_reg;
        push_item.last  = last;
        case (cfg.mode)
            stw_pkg::MODE_SCATTER: push_item.data = data_in;
            stw_pkg::MODE_FILL:    push_item.data = cfg.fill_value;
            default:               push_item.data = '0;
        endcase
    end

    assign push_pos = pos_reg;

    // odometer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            index_reg <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                pos_reg   <= '0;
                index_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                index_reg <= index_next;
            end
        end
    end

endmodule

### design/stw_queue.sv
// ----------------------------------------------------------------------------
// stw_queue: short FIFO between front end and address back end
// Register-based ring; the producer holds off while it is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stw_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_next;

    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### design/stw_back.sv
// ----------------------------------------------------------------------------
// stw_back: strided address back end
// Stage A multiplies each position by its stride; stage B sums the products
// with the base offset into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stw_back #(
    parameter int MAX_DIMS    = 4,
    parameter int EXTENT_BITS = 16,
    parameter int ADDR_BITS   = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  stw_pkg::stw_cfg_t                     cfg,
    input  logic [stw_pkg::CFG_BITS-1:0]          strides,
    input  logic                                  q_not_empty,
    input  logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  q_pos,
    input  stw_pkg::stw_item_t                    q_item,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ADDR_BITS-1:0]                  strided_address,
    output logic [stw_pkg::INDEX_BITS-1:0]        compact_index,
    output logic [stw_pkg::DATA_BITS-1:0]         write_data,
    output logic                                  is_last
);

    localparam int SPAN      = MAX_DIMS * EXTENT_BITS + stw_pkg::CFG_BITS;
    localparam int PROD_BITS = 2 * EXTENT_BITS;
    localparam int WIDE_BITS = (ADDR_BITS > PROD_BITS) ? ADDR_BITS : PROD_BITS;
    localparam int SUM_BITS  = (WIDE_BITS > 32) ? WIDE_BITS : 32;
    // the address field carries at most 32 bits
    localparam int KEEP_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;

    logic [SPAN-1:0]                      str_padded;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] stride_vec;
    logic [3:0]                           n_dims;

    logic                                 a_valid_reg;
    logic [MAX_DIMS-1:0][PROD_BITS-1:0]   a_prod_reg;
    logic [MAX_DIMS-1:0][PROD_BITS-1:0]   a_prod_next;
    stw_pkg::stw_item_t                   a_item_reg;

    logic                                 out_valid_reg;
    logic [ADDR_BITS-1:0]                 addr_reg;
    logic [ADDR_BITS-1:0]                 addr_next;
    stw_pkg::stw_item_t                   out_item_reg;
    logic [SUM_BITS-1:0]                  sum;

    logic                                 out_load;
    logic                                 a_advance;

    assign str_padded = SPAN'(strides);
    assign stride_vec = str_padded[MAX_DIMS*EXTENT_BITS-1:0];
    assign n_dims     = stw_pkg::used_dims(cfg.dim_count, MAX_DIMS);

    // pipeline flow: each stage moves when the one after it has room
    assign out_load  = a_valid_reg && (!out_valid_reg || !out_stall);
    assign a_advance = !a_valid_reg || out_load;
    assign q_pop     = q_not_empty && a_advance;

    // stage A: one product per used dimension
    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (4'(d) < n_dims)
                a_prod_next[d] = PROD_BITS'(q_pos[d]) * PROD_BITS'(stride_vec[d]);
            else
                a_prod_next[d] = '0;
        end
    end

    // stage B: base plus products, wrapped to the address width but to at most 32 bits
    always_comb
    begin
        sum = SUM_BITS'(cfg.base_offset);
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            sum = sum + SUM_BITS'(a_prod_reg[d]);
        end
        addr_next = ADDR_BITS'(sum[KEEP_BITS-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_advance)
                a_valid_reg <= q_not_empty;
            if (!out_valid_reg || !out_stall)
                out_valid_reg <= a_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_prod_reg <= a_prod_next;
            a_item_reg <= q_item;
        end
        if (out_load)
        begin
            addr_reg     <= addr_next;
            out_item_reg <= a_item_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign strided_address = addr_reg;
    assign compact_index   = out_item_reg.index;
    assign write_data      = out_item_reg.data;
    assign is_last         = out_item_reg.last;

endmodule

### design/strided_tensor_address_walker.sv
// An accepted beat passes the queue, the product register and the output register.
// One element per cycle while out_stall is low; both stages hold while it stalls.
// A two-entry queue splits the odometer from the address pipeline, so input
// keeps flowing while a result waits on out_stall, until the queue fills.
// Reset (rst_n, async, active low) clears the odometer, the queue pointers and the
// valid flags and loads the configuration defaults; payload registers are not reset.
// ----------------------------------------------------------------------------
// strided_tensor_address_walker: strided N-d address generator
// Configuration registers, odometer front end, queue and address back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strided_tensor_address_walker #(
    parameter int MAX_DIMS    = 4,
    parameter int EXTENT_BITS = 16,
    parameter int ADDR_BITS   = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [stw_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [stw_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [stw_pkg::DATA_BITS-1:0]        data_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ADDR_BITS-1:0]                 strided_address,
    output logic [stw_pkg::INDEX_BITS-1:0]       compact_index,
    output logic [stw_pkg::DATA_BITS-1:0]        write_data,
    output logic                                 is_last
);

    localparam int POS_BITS = MAX_DIMS * EXTENT_BITS;
    localparam int Q_WIDTH  = POS_BITS + $bits(stw_pkg::stw_item_t);

    stw_pkg::stw_cfg_t                    cfg_reg;
    logic [stw_pkg::CFG_BITS-1:0]         extents_reg;
    logic [stw_pkg::CFG_BITS-1:0]         strides_reg;

    logic                                 push;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] push_pos;
    stw_pkg::stw_item_t                   push_item;
    logic                                 q_full;
    logic                                 q_pop;
    logic                                 q_not_empty;
    logic [Q_WIDTH-1:0]                   q_pop_data;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] q_pos;
    stw_pkg::stw_item_t                   q_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= stw_pkg::MODE_GATHER;
            cfg_reg.dim_count     <= 3'd1;
            cfg_reg.base_offset   <= '0;
            cfg_reg.element_count <= stw_pkg::COUNT_BITS'(1);
            cfg_reg.fill_value    <= '0;
            extents_reg           <= '0;
            strides_reg           <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                stw_pkg::REG_MODE:          cfg_reg.mode          <= cfg_data[1:0];
                stw_pkg::REG_DIM_COUNT:     cfg_reg.dim_count     <= cfg_data[2:0];
                stw_pkg::REG_BASE_OFFSET:   cfg_reg.base_offset   <= cfg_data[31:0];
                stw_pkg::REG_EXTENTS:       extents_reg           <= cfg_data;
                stw_pkg::REG_STRIDES:       strides_reg           <= cfg_data;
                stw_pkg::REG_ELEMENT_COUNT:
                    cfg_reg.element_count <= cfg_data[stw_pkg::COUNT_BITS-1:0];
                stw_pkg::REG_FILL_VALUE:
                    cfg_reg.fill_value    <= cfg_data[stw_pkg::DATA_BITS-1:0];
                default: ;
            endcase
        end
    end

    stw_front #(
        .MAX_DIMS    (MAX_DIMS),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .extents    (extents_reg),
        .in_valid   (in_valid),
        .data_in    (data_in),
        .in_stall   (in_stall),
        .queue_full (q_full),
        .push       (push),
        .push_pos   (push_pos),
        .push_item  (push_item)
    );

    stw_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (stw_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_pos, push_item}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    assign q_pos  = q_pop_data[Q_WIDTH-1 -: POS_BITS];
    assign q_item = q_pop_data[$bits(stw_pkg::stw_item_t)-1:0];

    stw_back #(
        .MAX_DIMS    (MAX_DIMS),
        .EXTENT_BITS (EXTENT_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .strides         (strides_reg),
        .q_not_empty     (q_not_empty),
        .q_pos           (q_pos),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .strided_address (strided_address),
        .compact_index   (compact_index),
        .write_data      (write_data),
        .is_last         (is_last)
    );

endmodule

### design/stw_checker.sv
// ----------------------------------------------------------------------------
// stw_checker: port-level checks for the strided tensor address walker
// Tracks beats in flight and the expected compact index sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stw_checker #(
    parameter int ADDR_BITS = 32
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [ADDR_BITS-1:0]              strided_address,
    input logic [stw_pkg::INDEX_BITS-1:0]    compact_index,
    input logic [stw_pkg::DATA_BITS-1:0]     write_data,
    input logic                              is_last
);

    // queue plus the multiply stage plus the output register
    localparam int PENDING_LIMIT = stw_pkg::QUEUE_DEPTH + 2;

    logic [2:0]                     pending_reg;
    logic [stw_pkg::INDEX_BITS-1:0] exp_index_reg;
    logic                           in_beat;
    logic                           out_beat;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            exp_index_reg <= '0;
        end
        else
        begin
            if (in_beat && !out_beat)
                pending_reg <= pending_reg + 3'd1;
            else if (out_beat && !in_beat)
                pending_reg <= pending_reg - 3'd1;
            if (out_beat)
                exp_index_reg <= is_last ? '0 : compact_index + stw_pkg::INDEX_BITS'(1);
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(strided_address)
            && $stable(compact_index) && $stable(write_data) && $stable(is_last))
        else $error("stalled result changed");

    // compact index counts up and restarts after the final element
    a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> compact_index == exp_index_reg)
        else $error("compact index out of sequence");

    // never more beats in flight than the storage holds
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(PENDING_LIMIT))
        else $error("too many beats in flight");

    // no result without an accepted input beat behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result with no beat in flight");

endmodule

bind strided_tensor_address_walker stw_checker #(
    .ADDR_BITS (ADDR_BITS)
) u_stw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .strided_address (strided_address),
    .compact_index   (compact_index),
    .write_data      (write_data),
    .is_last         (is_last)
);
